@@ hw/rtl/sbd_pkg.sv @@
// Shared types, constants and helpers for the system bus decoder.
// Used by sbd_front, sbd_queue, sbd_back and the top level.
package sbd_pkg;

	localparam int BOARD_RAM_BYTES = 262144;
	localparam int CHIP_RAM_BYTES  = 32768;
	localparam int PALETTE_BYTES   = 1024;
	localparam int VIDEO_RAM_BYTES = 98304;
	localparam int ATTRIBUTE_BYTES = 1024;

	localparam int BOARD_AW = $clog2(BOARD_RAM_BYTES);
	localparam int CHIP_AW  = $clog2(CHIP_RAM_BYTES);
	localparam int PAL_AW   = $clog2(PALETTE_BYTES);
	localparam int VID_AW   = $clog2(VIDEO_RAM_BYTES);
	localparam int ATTR_AW  = $clog2(ATTRIBUTE_BYTES);

	// wide enough for the largest mirror mask and the largest store size
	localparam int OFF_W = 19;

	localparam logic [31:0] BIOS_LAST  = 32'h0000_3FFF;
	localparam logic [31:0] CART_FIRST = 32'h0800_0000;
	localparam logic [31:0] CART_LAST  = 32'h0DFF_FFFF;
	localparam logic [31:0] CART_MASK  = 32'h01FF_FFFF;
	localparam logic [31:0] BOARD_MASK = 32'h0003_FFFF;
	localparam logic [31:0] CHIP_MASK  = 32'h0000_7FFF;
	localparam logic [31:0] PAL_MASK   = 32'h0000_03FF;
	localparam logic [31:0] VID_MASK   = 32'h0001_7FFF;
	localparam logic [31:0] ATTR_MASK  = 32'h0000_03FF;

	localparam logic [7:0] PAGE_BOARD = 8'h02;
	localparam logic [7:0] PAGE_CHIP  = 8'h03;
	localparam logic [7:0] PAGE_IO    = 8'h04;
	localparam logic [7:0] PAGE_PAL   = 8'h05;
	localparam logic [7:0] PAGE_VID   = 8'h06;
	localparam logic [7:0] PAGE_ATTR  = 8'h07;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [1:0] SZ_BYTE = 2'd0;
	localparam logic [1:0] SZ_HALF = 2'd1;
	localparam logic [1:0] SZ_WORD = 2'd2;
	localparam logic [1:0] SZ_BAD  = 2'd3;

	typedef enum logic [3:0] {
		REG_BIOS  = 4'd0,
		REG_CART  = 4'd1,
		REG_BOARD = 4'd2,
		REG_CHIP  = 4'd3,
		REG_IO    = 4'd4,
		REG_PAL   = 4'd5,
		REG_VID   = 4'd6,
		REG_ATTR  = 4'd7,
		REG_NONE  = 4'd8
	} region_t;

	typedef enum logic [2:0] {
		ST_BOARD,
		ST_CHIP,
		ST_PAL,
		ST_VID,
		ST_ATTR
	} store_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_REDUCE,
		S_ACCESS,
		S_FINISH,
		S_OUT
	} bk_state_t;

	typedef struct packed {
		logic             wr;
		logic [1:0]       sz;
		logic [31:0]      wdata;
		region_t          region;
		logic             fault;
		logic             ext_req;
		logic [24:0]      ext_addr;
		logic [1:0]       ext_sz;
		logic             ext_wr;
		logic [31:0]      ext_wd;
		logic             mem;
		store_t           st;
		logic [OFF_W-1:0] off;
	} cmd_t;

	function automatic logic [31:0] size_mask(input logic [1:0] sz);
		logic [31:0] m;
		unique case (sz)
			SZ_BYTE: m = 32'h0000_00FF;
			SZ_HALF: m = 32'h0000_FFFF;
			default: m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

	function automatic logic [1:0] last_lane(input logic [1:0] sz);
		logic [1:0] l;
		unique case (sz)
			SZ_BYTE: l = 2'd0;
			SZ_HALF: l = 2'd1;
			default: l = 2'd3;
		endcase
		return l;
	endfunction

	function automatic logic [OFF_W-1:0] store_bytes(input store_t st);
		logic [OFF_W-1:0] b;
		unique case (st)
			ST_BOARD: b = OFF_W'(BOARD_RAM_BYTES);
			ST_CHIP:  b = OFF_W'(CHIP_RAM_BYTES);
			ST_PAL:   b = OFF_W'(PALETTE_BYTES);
			ST_VID:   b = OFF_W'(VIDEO_RAM_BYTES);
			default:  b = OFF_W'(ATTRIBUTE_BYTES);
		endcase
		return b;
	endfunction

endpackage

@@ hw/rtl/system_bus_decode_and_memories_unit.sv @@
// System bus decoder with internal byte memories (top level).
// External, I/O and faulting transactions go from idle straight to the output state;
// memory transactions pass through offset reduction steps, one access per byte lane (1, 2 or
// 4 lanes) and a finish state. The back end holds one transaction at a time and uses a
// one-byte-per-cycle memory port; a two-entry queue lets the front run ahead.
// Reset clears control state only; memory contents are undefined until written.
module system_bus_decode_and_memories_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [1:0]  access_size,
	input  logic [31:0] bus_address,
	input  logic [31:0] write_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] read_data,
	output logic [3:0]  region,
	output logic        ext_request,
	output logic [24:0] ext_address,
	output logic [1:0]  ext_size,
	output logic        ext_write,
	output logic [31:0] ext_write_data,
	output logic        fault
);
	import sbd_pkg::*;

	cmd_t front_cmd;
	cmd_t head_cmd;
	logic head_valid;
	logic head_pop;

	sbd_front u_front (
		.opcode      (opcode),
		.access_size (access_size),
		.bus_address (bus_address),
		.write_data  (write_data),
		.cmd         (front_cmd)
	);

	sbd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (in_ready),
		.push_cmd   (front_cmd),
		.pop_valid  (head_valid),
		.pop        (head_pop),
		.pop_cmd    (head_cmd)
	);

	sbd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (head_valid),
		.q_pop          (head_pop),
		.q_cmd          (head_cmd),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.read_data      (read_data),
		.region         (region),
		.ext_request    (ext_request),
		.ext_address    (ext_address),
		.ext_size       (ext_size),
		.ext_write      (ext_write),
		.ext_write_data (ext_write_data),
		.fault          (fault)
	);

endmodule

@@ hw/rtl/sbd_front.sv @@
// Front end: decodes the address into a region and classifies the access.
// Depends on sbd_pkg.
module sbd_front (
	input  logic            opcode,
	input  logic [1:0]      access_size,
	input  logic [31:0]     bus_address,
	input  logic [31:0]     write_data,
	output sbd_pkg::cmd_t   cmd
);
	import sbd_pkg::*;

	region_t          rg;
	store_t           st;
	logic [OFF_W-1:0] off;
	logic             wr;
	logic             display;
	logic             fault;
	logic             ext;

	always_comb begin
		rg = REG_NONE;
		if (bus_address <= BIOS_LAST) begin
			rg = REG_BIOS;
		end else if (bus_address >= CART_FIRST && bus_address <= CART_LAST) begin
			rg = REG_CART;
		end else begin
			unique case (bus_address[31:24])
				PAGE_BOARD: rg = REG_BOARD;
				PAGE_CHIP:  rg = REG_CHIP;
				PAGE_IO:    rg = REG_IO;
				PAGE_PAL:   rg = REG_PAL;
				PAGE_VID:   rg = REG_VID;
				PAGE_ATTR:  rg = REG_ATTR;
				default:    rg = REG_NONE;
			endcase
		end
	end

	always_comb begin
		unique case (rg)
			REG_BOARD: begin
				st  = ST_BOARD;
				off = OFF_W'(bus_address & BOARD_MASK);
			end
			REG_CHIP: begin
				st  = ST_CHIP;
				off = OFF_W'(bus_address & CHIP_MASK);
			end
			REG_PAL: begin
				st  = ST_PAL;
				off = OFF_W'(bus_address & PAL_MASK);
			end
			REG_VID: begin
				st  = ST_VID;
				off = OFF_W'(bus_address & VID_MASK);
			end
			REG_ATTR: begin
				st  = ST_ATTR;
				off = OFF_W'(bus_address & ATTR_MASK);
			end
			default: begin
				st  = ST_BOARD;
				off = '0;
			end
		endcase
	end

	assign wr      = (opcode == OP_WRITE);
	assign display = (rg == REG_PAL) || (rg == REG_VID) || (rg == REG_ATTR);
	assign fault   = (access_size == SZ_BAD) || (rg == REG_NONE) ||
	                 ((rg == REG_BIOS) && wr) || (wr && (access_size == SZ_BYTE) && display);
	assign ext     = !fault && ((rg == REG_BIOS) || (rg == REG_CART));

	always_comb begin
		cmd          = '0;
		cmd.wr       = wr;
		cmd.sz       = access_size;
		cmd.wdata    = write_data;
		cmd.region   = rg;
		cmd.fault    = fault;
		cmd.ext_req  = ext;
		cmd.ext_addr = ext ? 25'(bus_address & CART_MASK) : '0;
		cmd.ext_sz   = ext ? access_size : SZ_BYTE;
		cmd.ext_wr   = ext && wr;
		cmd.ext_wd   = (ext && wr) ? (write_data & size_mask(access_size)) : '0;
		cmd.mem      = !fault && ((rg == REG_BOARD) || (rg == REG_CHIP) || display);
		cmd.st       = st;
		cmd.off      = off;
	end

endmodule

@@ hw/rtl/sbd_queue.sv @@
// Two-entry command queue between the decode front and the memory back end.
// Depends on sbd_pkg.
module sbd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  sbd_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop,
	output sbd_pkg::cmd_t pop_cmd
);
	import sbd_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_cmd    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

@@ hw/rtl/sbd_back.sv @@
// Back end: reduces the offset into the store, walks the byte lanes through the
// selected byte memory and holds the result. Depends on sbd_pkg.
module sbd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_pop,
	input  sbd_pkg::cmd_t q_cmd,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [31:0]   read_data,
	output logic [3:0]    region,
	output logic          ext_request,
	output logic [24:0]   ext_address,
	output logic [1:0]    ext_size,
	output logic          ext_write,
	output logic [31:0]   ext_write_data,
	output logic          fault
);
	import sbd_pkg::*;

	bk_state_t        state_q;
	bk_state_t        state_d;
	cmd_t             cur_q;
	logic [OFF_W-1:0] idx_q;
	logic [OFF_W-1:0] bytes;
	logic [OFF_W-1:0] idx_inc;
	logic [1:0]       lane_q;
	logic             pend_q;
	logic [1:0]       pend_lane_q;
	logic [31:0]      rdata_q;
	logic             mem_en;
	logic             mem_we;
	logic [7:0]       wbyte;
	logic [7:0]       rd_byte;

	logic [7:0] board_mem [BOARD_RAM_BYTES];
	logic [7:0] chip_mem  [CHIP_RAM_BYTES];
	logic [7:0] pal_mem   [PALETTE_BYTES];
	logic [7:0] vid_mem   [VIDEO_RAM_BYTES];
	logic [7:0] attr_mem  [ATTRIBUTE_BYTES];
	logic [7:0] board_rd_q;
	logic [7:0] chip_rd_q;
	logic [7:0] pal_rd_q;
	logic [7:0] vid_rd_q;
	logic [7:0] attr_rd_q;

	assign bytes   = store_bytes(cur_q.st);
	assign idx_inc = idx_q + OFF_W'(1);
	assign wbyte   = cur_q.wdata[{lane_q, 3'b000} +: 8];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					state_d = q_cmd.mem ? S_REDUCE : S_OUT;
				end
			end
			S_REDUCE: begin
				if (idx_q < bytes) begin
					state_d = S_ACCESS;
				end
			end
			S_ACCESS: begin
				if (lane_q == last_lane(cur_q.sz)) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: state_d = S_OUT;
			S_OUT: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = (state_q == S_IDLE) && q_valid;
		mem_en    = (state_q == S_ACCESS);
		mem_we    = mem_en && cur_q.wr;
		out_valid = (state_q == S_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= mem_en && !cur_q.wr;
		end
	end

	always_ff @(posedge clk) begin
		pend_lane_q <= lane_q;
		if (q_pop) begin
			cur_q   <= q_cmd;
			idx_q   <= q_cmd.off;
			lane_q  <= 2'd0;
			rdata_q <= '0;
		end else begin
			if (state_q == S_REDUCE && idx_q >= bytes) begin
				idx_q <= idx_q - bytes;
			end
			if (mem_en) begin
				lane_q <= lane_q + 2'd1;
				idx_q  <= (idx_inc == bytes) ? '0 : idx_inc;
			end
			if (pend_q) begin
				rdata_q[{pend_lane_q, 3'b000} +: 8] <= rd_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we && cur_q.st == ST_BOARD) begin
			board_mem[idx_q[BOARD_AW-1:0]] <= wbyte;
		end
		board_rd_q <= board_mem[idx_q[BOARD_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (mem_we && cur_q.st == ST_CHIP) begin
			chip_mem[idx_q[CHIP_AW-1:0]] <= wbyte;
		end
		chip_rd_q <= chip_mem[idx_q[CHIP_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (mem_we && cur_q.st == ST_PAL) begin
			pal_mem[idx_q[PAL_AW-1:0]] <= wbyte;
		end
		pal_rd_q <= pal_mem[idx_q[PAL_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (mem_we && cur_q.st == ST_VID) begin
			vid_mem[idx_q[VID_AW-1:0]] <= wbyte;
		end
		vid_rd_q <= vid_mem[idx_q[VID_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (mem_we && cur_q.st == ST_ATTR) begin
			attr_mem[idx_q[ATTR_AW-1:0]] <= wbyte;
		end
		attr_rd_q <= attr_mem[idx_q[ATTR_AW-1:0]];
	end

	always_comb begin
		unique case (cur_q.st)
			ST_BOARD: rd_byte = board_rd_q;
			ST_CHIP:  rd_byte = chip_rd_q;
			ST_PAL:   rd_byte = pal_rd_q;
			ST_VID:   rd_byte = vid_rd_q;
			default:  rd_byte = attr_rd_q;
		endcase
	end

	assign read_data      = rdata_q;
	assign region         = 4'(cur_q.region);
	assign ext_request    = cur_q.ext_req;
	assign ext_address    = cur_q.ext_addr;
	assign ext_size       = cur_q.ext_sz;
	assign ext_write      = cur_q.ext_wr;
	assign ext_write_data = cur_q.ext_wd;
	assign fault          = cur_q.fault;

	a_idx_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ACCESS |-> idx_q < bytes)
		else $error("store index past store end during lane access");

	a_fault_no_ext: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(fault && ext_request))
		else $error("faulting access forwarded to external port");

	a_finish_after_access: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FINISH |-> $past(state_q) == S_ACCESS)
		else $error("finish entered without lane access");

	a_no_data_off_store: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (ext_request || fault) |-> read_data == 32'd0)
		else $error("read data returned for non-store transaction");

endmodule

@@ tb/system_bus_decode_and_memories_unit_tb.sv @@
// Self-checking bench for the system bus decoder and its internal memories.
// Predicts every transaction against local copies of the byte stores.
// Depends on sbd_pkg and system_bus_decode_and_memories_unit.
module system_bus_decode_and_memories_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sbd_pkg::*;

	typedef struct {
		logic        op;
		logic [1:0]  sz;
		logic [31:0] addr;
		logic [31:0] wdata;
	} bus_access_t;

	typedef struct packed {
		logic [31:0] rdata;
		region_t     region;
		logic        ext_req;
		logic [24:0] ext_addr;
		logic [1:0]  ext_sz;
		logic        ext_wr;
		logic [31:0] ext_wd;
		logic        fault;
	} bus_result_t;

	typedef struct {
		store_t      st;
		logic [31:0] off;
		logic [1:0]  sz;
	} written_span_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        opcode;
	logic [1:0]  access_size;
	logic [31:0] bus_address;
	logic [31:0] write_data;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] read_data;
	logic [3:0]  region;
	logic        ext_request;
	logic [24:0] ext_address;
	logic [1:0]  ext_size;
	logic        ext_write;
	logic [31:0] ext_write_data;
	logic        fault;

	logic [7:0] board_mem [BOARD_RAM_BYTES];
	logic [7:0] chip_mem [CHIP_RAM_BYTES];
	logic [7:0] palette_mem [PALETTE_BYTES];
	logic [7:0] video_mem [VIDEO_RAM_BYTES];
	logic [7:0] attribute_mem [ATTRIBUTE_BYTES];

	bus_access_t   pending_accesses [$];
	bus_result_t   predicted_results [$];
	written_span_t written_spans [$];

	bus_access_t next_access;
	bit          have_item;
	bit          in_taken;
	bit          out_taken;
	bit          rx_hold;
	bit          tx_calm;
	bit          rx_calm;
	int unsigned tx_gap;
	int unsigned rx_gap;
	int unsigned tx_phase_left;
	int unsigned rx_phase_left;
	int unsigned accepted_cnt;
	int unsigned mismatch_cnt;

	system_bus_decode_and_memories_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.access_size   (access_size),
		.bus_address   (bus_address),
		.write_data    (write_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.read_data     (read_data),
		.region        (region),
		.ext_request   (ext_request),
		.ext_address   (ext_address),
		.ext_size      (ext_size),
		.ext_write     (ext_write),
		.ext_write_data(ext_write_data),
		.fault         (fault)
	);

	function automatic bus_result_t predict_bus_access(logic wr, logic [1:0] sz, logic [31:0] a,
			logic [31:0] wd);
		bus_result_t r;
		int unsigned off;
		int unsigned nbytes;
		int unsigned idx;
		int unsigned lanes;
		r = '0;
		off = 0;
		nbytes = 1;
		if (a <= BIOS_LAST) begin
			r.region = REG_BIOS;
		end else if (a >= CART_FIRST && a <= CART_LAST) begin
			r.region = REG_CART;
		end else begin
			case (a[31:24])
				PAGE_BOARD: r.region = REG_BOARD;
				PAGE_CHIP:  r.region = REG_CHIP;
				PAGE_IO:    r.region = REG_IO;
				PAGE_PAL:   r.region = REG_PAL;
				PAGE_VID:   r.region = REG_VID;
				PAGE_ATTR:  r.region = REG_ATTR;
				default:    r.region = REG_NONE;
			endcase
		end
		case (r.region)
			REG_BOARD: begin nbytes = BOARD_RAM_BYTES; off = a & BOARD_MASK; end
			REG_CHIP:  begin nbytes = CHIP_RAM_BYTES;  off = a & CHIP_MASK;  end
			REG_PAL:   begin nbytes = PALETTE_BYTES;   off = a & PAL_MASK;   end
			REG_VID:   begin nbytes = VIDEO_RAM_BYTES; off = a & VID_MASK;   end
			REG_ATTR:  begin nbytes = ATTRIBUTE_BYTES; off = a & ATTR_MASK;  end
			default:   ;
		endcase
		if (sz == SZ_BAD || r.region == REG_NONE) begin
			r.fault = 1'b1;
		end else if (r.region inside {REG_BIOS, REG_CART}) begin
			if (r.region == REG_BIOS && wr == OP_WRITE) begin
				r.fault = 1'b1;
			end else begin
				r.ext_req = 1'b1;
				r.ext_addr = (r.region == REG_CART) ? 25'(a & CART_MASK) : 25'(a);
				r.ext_sz = sz;
				r.ext_wr = wr;
				if (wr == OP_WRITE) begin
					r.ext_wd = (sz == SZ_BYTE) ? (wd & 32'h0000_00FF) :
						(sz == SZ_HALF) ? (wd & 32'h0000_FFFF) : wd;
				end
			end
		end else if (r.region == REG_IO) begin
			r.fault = 1'b0;
		end else if (wr == OP_WRITE && sz == SZ_BYTE && r.region inside {REG_PAL, REG_VID, REG_ATTR}) begin
			r.fault = 1'b1;
		end else begin
			lanes = 1 << sz;
			for (int i = 0; i < lanes; i++) begin
				idx = (off + i) % nbytes;
				case (r.region)
					REG_BOARD: if (wr) board_mem[idx] = wd[8*i +: 8];
						else r.rdata[8*i +: 8] = board_mem[idx];
					REG_CHIP:  if (wr) chip_mem[idx] = wd[8*i +: 8];
						else r.rdata[8*i +: 8] = chip_mem[idx];
					REG_PAL:   if (wr) palette_mem[idx] = wd[8*i +: 8];
						else r.rdata[8*i +: 8] = palette_mem[idx];
					REG_VID:   if (wr) video_mem[idx] = wd[8*i +: 8];
						else r.rdata[8*i +: 8] = video_mem[idx];
					default:   if (wr) attribute_mem[idx] = wd[8*i +: 8];
						else r.rdata[8*i +: 8] = attribute_mem[idx];
				endcase
			end
		end
		return r;
	endfunction

	function automatic string format_result(bus_result_t r);
		return $sformatf("rd=%h rg=%0d xr=%b xa=%h xs=%0d xw=%b xd=%h f=%b", r.rdata, r.region,
			r.ext_req, r.ext_addr, r.ext_sz, r.ext_wr, r.ext_wd, r.fault);
	endfunction

	function automatic logic [31:0] mirror_address(store_t st, logic [31:0] off);
		logic [7:0]  page;
		logic [31:0] mask;
		case (st)
			ST_BOARD: begin page = PAGE_BOARD; mask = BOARD_MASK; end
			ST_CHIP:  begin page = PAGE_CHIP;  mask = CHIP_MASK;  end
			ST_PAL:   begin page = PAGE_PAL;   mask = PAL_MASK;   end
			ST_VID:   begin page = PAGE_VID;   mask = VID_MASK;   end
			default:  begin page = PAGE_ATTR;  mask = ATTR_MASK;  end
		endcase
		return {page, 24'h0} | ($urandom & 32'h00FF_FFFF & ~mask) | (off & mask);
	endfunction

	function automatic logic [31:0] random_offset(store_t st);
		logic [31:0] mask;
		int unsigned nbytes;
		case (st)
			ST_BOARD: begin mask = BOARD_MASK; nbytes = BOARD_RAM_BYTES; end
			ST_CHIP:  begin mask = CHIP_MASK;  nbytes = CHIP_RAM_BYTES;  end
			ST_PAL:   begin mask = PAL_MASK;   nbytes = PALETTE_BYTES;   end
			ST_VID:   begin mask = VID_MASK;   nbytes = VIDEO_RAM_BYTES; end
			default:  begin mask = ATTR_MASK;  nbytes = ATTRIBUTE_BYTES; end
		endcase
		if ($urandom_range(0, 3) == 0) begin
			return nbytes - 1 - $urandom_range(0, 3);
		end
		return $urandom & mask;
	endfunction

	task automatic enqueue_access(logic op, logic [1:0] sz, logic [31:0] a, logic [31:0] wd);
		bus_access_t t;
		t.op = op;
		t.sz = sz;
		t.addr = a;
		t.wdata = wd;
		pending_accesses.push_back(t);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// drive inputs on the falling edge; hold the transaction until accepted
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_taken)) begin
			if (!have_item && pending_accesses.size() != 0) begin
				next_access = pending_accesses.pop_front();
				have_item = 1'b1;
				if (tx_phase_left == 0) begin
					tx_calm = ($urandom_range(0, 3) == 0);
					tx_phase_left = $urandom_range(16, 64);
				end
				tx_phase_left--;
				tx_gap = tx_calm ? 0 : $urandom_range(0, 8);
			end
			if (have_item && tx_gap == 0) begin
				opcode <= next_access.op;
				access_size <= next_access.sz;
				bus_address <= next_access.addr;
				write_data <= next_access.wdata;
				in_valid <= 1'b1;
				have_item = 1'b0;
			end else begin
				in_valid <= 1'b0;
				if (have_item) tx_gap--;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (out_taken) begin
				if (rx_phase_left == 0) begin
					rx_calm = ($urandom_range(0, 3) == 0);
					rx_phase_left = $urandom_range(16, 64);
				end
				rx_phase_left--;
				rx_gap = rx_calm ? 0 : $urandom_range(0, 8);
			end
			if (rx_hold) begin
				out_ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		bus_result_t got;
		bus_result_t want;
		if (arst_n) begin
			in_taken = in_valid && in_ready;
			out_taken = out_valid && out_ready;
			if (in_taken) begin
				predicted_results.push_back(predict_bus_access(opcode, access_size, bus_address,
					write_data));
				accepted_cnt++;
			end
			if (out_taken) begin
				got = '{read_data, region_t'(region), ext_request, ext_address, ext_size, ext_write,
					ext_write_data, fault};
				if (predicted_results.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10) $display("unexpected result %s", format_result(got));
				end else begin
					want = predicted_results.pop_front();
					if (got !== want) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10) begin
							$display("mismatch exp %s", format_result(want));
							$display("         got %s", format_result(got));
						end
					end
				end
			end
		end
	end

	// hold off the receiver long enough for the block to back up
	initial begin
		rx_hold = 1'b0;
		wait (accepted_cnt >= 300);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (150) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		written_span_t span;
		store_t        st;
		logic          op;
		logic [1:0]    sz;
		logic [31:0]   off;
		logic [31:0]   a;
		int unsigned   pick;

		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		opcode = OP_READ;
		access_size = SZ_BYTE;
		bus_address = '0;
		write_data = '0;
		have_item = 1'b0;
		in_taken = 1'b0;
		out_taken = 1'b0;
		tx_gap = 0;
		rx_gap = 0;
		tx_phase_left = 0;
		rx_phase_left = 0;
		accepted_cnt = 0;
		mismatch_cnt = 0;

		enqueue_access(OP_READ,  SZ_WORD, 32'h0000_0000, 32'h0);
		enqueue_access(OP_READ,  SZ_BYTE, 32'h0000_3FFF, 32'hFFFF_FFFF);
		enqueue_access(OP_WRITE, SZ_HALF, 32'h0000_0100, 32'h1234_5678);
		enqueue_access(OP_READ,  SZ_WORD, 32'h0800_0000, 32'h0);
		enqueue_access(OP_WRITE, SZ_WORD, 32'h0DFF_FFFF, 32'hFFFF_FFFF);
		enqueue_access(OP_WRITE, SZ_BYTE, 32'h09AB_CDEF, 32'hA5A5_A5A5);
		enqueue_access(OP_READ,  SZ_WORD, 32'h0000_4000, 32'h0);
		enqueue_access(OP_READ,  SZ_HALF, 32'h0E00_0000, 32'h0);
		enqueue_access(OP_WRITE, SZ_WORD, 32'hFFFF_FFFF, 32'hDEAD_BEEF);
		enqueue_access(OP_READ,  SZ_HALF, 32'h0400_0000, 32'h0);
		enqueue_access(OP_WRITE, SZ_WORD, 32'h04FF_FFFF, 32'hCAFE_F00D);
		enqueue_access(OP_WRITE, SZ_WORD, 32'h0203_FFFE, 32'h8765_4321);
		enqueue_access(OP_READ,  SZ_WORD, 32'h02FF_FFFE, 32'h0);
		enqueue_access(OP_READ,  SZ_BYTE, 32'h0200_0001, 32'h0);
		enqueue_access(OP_WRITE, SZ_WORD, 32'h03FF_FFFF, 32'h0102_0304);
		enqueue_access(OP_READ,  SZ_HALF, 32'h0300_7FFF, 32'h0);
		enqueue_access(OP_WRITE, SZ_BYTE, 32'h0500_0010, 32'h0000_00FF);
		enqueue_access(OP_WRITE, SZ_HALF, 32'h0500_03FF, 32'h0000_BEEF);
		enqueue_access(OP_READ,  SZ_HALF, 32'h05FF_FFFF, 32'h0);
		enqueue_access(OP_WRITE, SZ_WORD, 32'h0601_7FFF, 32'hF00D_FACE);
		enqueue_access(OP_READ,  SZ_WORD, 32'h0601_FFFF, 32'h0);
		enqueue_access(OP_WRITE, SZ_BYTE, 32'h0600_0100, 32'h0000_0055);
		enqueue_access(OP_WRITE, SZ_WORD, 32'h0700_0000, 32'h1357_9BDF);
		enqueue_access(OP_READ,  SZ_BYTE, 32'h07FF_FC00, 32'h0);
		enqueue_access(OP_WRITE, SZ_BYTE, 32'h0700_0002, 32'h0000_00AA);
		enqueue_access(OP_READ,  SZ_BAD,  32'h0200_0000, 32'h0);
		enqueue_access(OP_WRITE, SZ_BAD,  32'h0800_0000, 32'hFFFF_FFFF);

		for (int n = 0; n < 1000; n++) begin
			pick = $urandom_range(0, 99);
			op = 1'($urandom_range(0, 1));
			sz = 2'($urandom_range(0, 2));
			if (pick < 60) begin
				if (written_spans.size() != 0 && $urandom_range(0, 1)) begin
					span = written_spans[$urandom_range(0, written_spans.size() - 1)];
					enqueue_access(OP_READ, 2'($urandom_range(0, span.sz)),
						mirror_address(span.st, span.off), $urandom);
				end else begin
					st = store_t'($urandom_range(0, 4));
					off = random_offset(st);
					enqueue_access(OP_WRITE, sz, mirror_address(st, off), $urandom);
					if (sz != SZ_BYTE || st == ST_BOARD || st == ST_CHIP) begin
						span.st = st;
						span.off = off;
						span.sz = sz;
						written_spans.push_back(span);
						if (written_spans.size() > 64) void'(written_spans.pop_front());
					end
				end
			end else if (pick < 72) begin
				a = $urandom_range(0, 1) ? $urandom_range(0, BIOS_LAST) :
					$urandom_range(CART_FIRST, CART_LAST);
				enqueue_access(op, sz, a, $urandom);
			end else if (pick < 78) begin
				enqueue_access(op, sz, {PAGE_IO, 24'($urandom)}, $urandom);
			end else if (pick < 86) begin
				enqueue_access(op, SZ_BAD, $urandom, $urandom);
			end else begin
				// reads of memory pages could hit unwritten bytes: turn them into writes
				a = $urandom;
				sz = 2'($urandom_range(0, 3));
				if (op == OP_READ && sz != SZ_BAD &&
						a[31:24] inside {PAGE_BOARD, PAGE_CHIP, PAGE_PAL, PAGE_VID, PAGE_ATTR})
					op = OP_WRITE;
				enqueue_access(op, sz, a, $urandom);
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_accesses.size() != 0 || have_item || in_valid ||
				predicted_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatch_cnt == 0 && predicted_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
